// ----- rtl/horizontal_polyphase_scaler_1ch_unit_defines.svh -----
// assertion macros for the horizontal polyphase scaler
// depends on nothing; taken in by the top level with `include
`ifndef HORIZONTAL_POLYPHASE_SCALER_1CH_UNIT_DEFINES_SVH
`define HORIZONTAL_POLYPHASE_SCALER_1CH_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HPSC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HPSC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hpsc_pkg.sv -----
// shared types, codes and constants of the horizontal polyphase scaler
// depends on nothing
package hpsc_pkg;

    localparam int MODE_W     = 2;
    localparam int POS_W      = 11;
    localparam int TAP_W      = 3;
    localparam int VAL_W      = 16;
    localparam int PIX_W      = 8;
    localparam int TAPS_W     = 4;
    localparam int CLIP_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 14;
    localparam int PROD_W     = VAL_W + PIX_W + 1;

    localparam int LINE_PIXELS  = 2048;
    localparam int OUT_PIXELS   = 2048;
    localparam int MAX_TAPS_DEF = 8;
    localparam int Q_DEPTH      = 2;

    localparam logic [MODE_W-1:0] MODE_PIXEL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FACTOR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MAX = 2'd2;

    localparam logic [TAPS_W-1:0] TAPS_RST     = 4'd4;
    localparam logic [CLIP_W-1:0] CLIP_MIN_RST = 32'sd0;
    localparam logic [CLIP_W-1:0] CLIP_MAX_RST = 32'sd4177920;

    // classified item as it sits in the queue
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        logic              tap_ok;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    // back-end status seen by the top level
    typedef struct packed {
        logic busy;
        logic finish;
    } back_status_t;

endpackage

// ----- rtl/hpsc_if.sv -----
// channel interfaces: input items, result items and configuration writes
// depends on hpsc_pkg
interface hpsc_in_if import hpsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [TAP_W-1:0]  tap;
    logic [VAL_W-1:0]  value;

    modport source (output valid, mode, position, tap, value, input ready);
    modport sink   (input valid, mode, position, tap, value, output ready);
endinterface

interface hpsc_out_if import hpsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] out_index;

    modport source (output valid, pixel_out, out_index, input ready);
    modport sink   (input valid, pixel_out, out_index, output ready);
endinterface

interface hpsc_cfg_if import hpsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/hpsc_ram.sv -----
// generic single-write, single-read RAM with registered read data
// depends on nothing
module hpsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/hpsc_queue.sv -----
// small register fifo between the front and back ends
// depends on nothing
module hpsc_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/hpsc_front.sv -----
// front end: takes input transfers, checks the tap number, forms the factor address
// depends on hpsc_pkg and hpsc_in_if
module hpsc_front import hpsc_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    hpsc_in_if.sink                                       src,
    input  logic                                          q_full,
    output logic                                          q_push,
    output logic [CMD_W+$clog2(OUT_PIXELS*MAX_TAPS)-1:0]  q_wdata
);

    localparam int FA_W = $clog2(OUT_PIXELS * MAX_TAPS);

    cmd_t            cmd;
    logic [FA_W-1:0] faddr;

    assign src.ready = !q_full;
    assign q_push    = src.valid && !q_full;

    always_comb
    begin
        cmd.mode   = src.mode;
        cmd.pos    = src.position;
        cmd.value  = src.value;
        // taps past the store depth are dropped on write
        cmd.tap_ok = (5'(src.tap) < 5'(MAX_TAPS));
        // row base of the output pixel plus tap; the tap is zero for a compute
        faddr = FA_W'(src.position * MAX_TAPS)
              + ((src.mode == MODE_FACTOR) ? FA_W'(src.tap) : '0);
    end

    assign q_wdata = {cmd, faddr};

endmodule

// ----- rtl/hpsc_back.sv -----
// back end: store writes and the multiply-accumulate sequencer with the result register
// depends on hpsc_pkg, hpsc_out_if and hpsc_ram
module hpsc_back import hpsc_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_empty,
    input  logic [CMD_W+$clog2(OUT_PIXELS*MAX_TAPS)-1:0] q_rdata,
    output logic                                         q_pop,
    input  logic [TAPS_W-1:0]                            taps_in_use,
    input  logic [CLIP_W-1:0]                            clip_min,
    input  logic [CLIP_W-1:0]                            clip_max,
    hpsc_out_if.source                                   dst,
    output back_status_t                                 status
);

    localparam int FA_W  = $clog2(OUT_PIXELS * MAX_TAPS);
    localparam int LA_W  = $clog2(LINE_PIXELS);
    localparam int SA_W  = $clog2(OUT_PIXELS);
    localparam int TC_W  = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_ISSUE  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    cmd_t                      head;
    logic [FA_W-1:0]           head_faddr;
    logic [2:0]                state_reg, state_next;
    logic [TC_W-1:0]           tap_reg, tap_next;
    logic [TC_W-1:0]           n_eff;
    logic [LA_W-1:0]           start_reg, start_next;
    logic [FA_W-1:0]           fbase_reg, fbase_next;
    logic [POS_W-1:0]          idx_reg, idx_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      prod_vld_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]          pixel_reg, pixel_next;
    logic [POS_W-1:0]          oidx_reg, oidx_next;
    logic                      out_load;

    logic                      line_we, fac_we, start_we;
    logic [LA_W-1:0]           line_raddr;
    logic [FA_W-1:0]           fac_raddr;
    logic [PIX_W-1:0]          line_rdata;
    logic [VAL_W-1:0]          fac_rdata;
    logic [SA_W-1:0]           start_rdata;

    logic signed [CLIP_W-1:0]  acc_ext, lo_cl, hi_cl;

    assign head       = cmd_t'(q_rdata[CMD_W+FA_W-1:FA_W]);
    assign head_faddr = q_rdata[FA_W-1:0];

    // taps beyond the store depth saturate
    assign n_eff = ({1'b0, taps_in_use} > 5'(MAX_TAPS)) ? TC_W'(MAX_TAPS)
                                                        : TC_W'(taps_in_use);

    assign line_raddr = start_reg + LA_W'(tap_reg);
    assign fac_raddr  = fbase_reg + FA_W'(tap_reg);

    hpsc_ram #(.WIDTH(PIX_W), .DEPTH(LINE_PIXELS)) u_line_store (
        .clk   (clk),
        .we    (line_we),
        .waddr (LA_W'(head.pos)),
        .wdata (head.value[PIX_W-1:0]),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    hpsc_ram #(.WIDTH(VAL_W), .DEPTH(OUT_PIXELS * MAX_TAPS)) u_factor_store (
        .clk   (clk),
        .we    (fac_we),
        .waddr (head_faddr),
        .wdata (head.value),
        .raddr (fac_raddr),
        .rdata (fac_rdata)
    );

    hpsc_ram #(.WIDTH(SA_W), .DEPTH(OUT_PIXELS)) u_start_store (
        .clk   (clk),
        .we    (start_we),
        .waddr (SA_W'(head.pos)),
        .wdata (head.value[SA_W-1:0]),
        .raddr (SA_W'(head.pos)),
        .rdata (start_rdata)
    );

    // clamp, lower bound first
    always_comb
    begin
        acc_ext = {{(CLIP_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        lo_cl   = (acc_ext < $signed(clip_min)) ? $signed(clip_min) : acc_ext;
        hi_cl   = (lo_cl > $signed(clip_max)) ? $signed(clip_max) : lo_cl;
    end

    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        start_next  = start_reg;
        fbase_next  = fbase_reg;
        idx_next    = idx_reg;
        rd_vld_next = 1'b0;
        acc_next    = acc_reg;
        q_pop       = 1'b0;
        line_we     = 1'b0;
        fac_we      = 1'b0;
        start_we    = 1'b0;
        out_load    = 1'b0;
        pixel_next  = pixel_reg;
        oidx_next   = oidx_reg;

        if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (head.mode)
                        MODE_PIXEL:   line_we  = 1'b1;
                        MODE_FACTOR:  fac_we   = head.tap_ok;
                        MODE_START:   start_we = 1'b1;
                        MODE_COMPUTE:
                        begin
                            fbase_next = head_faddr;
                            idx_next   = head.pos;
                            state_next = ST_START;
                        end
                        default: ;
                    endcase
                end
            end
            ST_START:
            begin
                start_next = LA_W'(start_rdata);
                tap_next   = '0;
                acc_next   = '0;
                state_next = (n_eff == '0) ? ST_DRAIN : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                rd_vld_next = 1'b1;
                tap_next    = tap_reg + 1'b1;
                if (tap_reg == n_eff - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last product lands in the accumulator at this edge
                if (!rd_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || dst.ready)
                begin
                    out_load   = 1'b1;
                    pixel_next = hi_cl[FRAC_BITS+PIX_W-1:FRAC_BITS];
                    oidx_next  = idx_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = (out_valid_reg && !dst.ready) || out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            prod_vld_reg  <= rd_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tap_reg   <= tap_next;
        start_reg <= start_next;
        fbase_reg <= fbase_next;
        idx_reg   <= idx_next;
        acc_reg   <= acc_next;
        prod_reg  <= $signed(fac_rdata) * $signed({1'b0, line_rdata});
        pixel_reg <= pixel_next;
        oidx_reg  <= oidx_next;
    end

    assign dst.valid     = out_valid_reg;
    assign dst.pixel_out = pixel_reg;
    assign dst.out_index = oidx_reg;

    assign status.busy   = (state_reg != ST_IDLE);
    assign status.finish = (state_reg == ST_FINISH);

endmodule

// ----- rtl/horizontal_polyphase_scaler_1ch_unit.sv -----
// top level of the horizontal polyphase scaler for one 8-bit plane
// depends on hpsc_pkg, the channel interfaces, hpsc_front, hpsc_queue, hpsc_back
// and the assertion macros header
//
// Horizontal resampler for one 8-bit image plane. Every input transfer carries a mode:
// pixel write into the line store, factor write (signed, 14 fraction bits) for an
// output pixel and tap, start-index write for an output pixel, or compute. A compute
// sums factor times source pixel over taps_in_use taps (saturated to MAX_TAPS) from
// the output pixel's start index onward, wrapping at the line end, clamps the sum to
// clip_min then clip_max, and returns bits 21..14 together with the output index;
// writes return nothing. Items run strictly in order. The front end accepts a transfer
// whenever its two-entry queue has room; the back end takes one item at a time from
// the queue. A write is done as it is dequeued. A compute (taps_in_use resets to four)
// runs in order: the dequeue cycle issues the start-index read, the next cycle takes
// it, then one tap a cycle through the single multiply-accumulate unit fed by the line
// and factor memories, then the memory read and the product register drain and the
// clamp is applied. The result sits in an output register, so the back end moves on
// while it waits to be taken, and stalls only when a second result is ready before
// the first has gone.
// Store contents are undefined until written and there is no clearing pass after
// reset. Configuration writes are always taken and must only be issued while the block
// is idle.
`include "horizontal_polyphase_scaler_1ch_unit_defines.svh"

module horizontal_polyphase_scaler_1ch_unit import hpsc_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    hpsc_in_if.sink     src,
    hpsc_out_if.source  dst,
    hpsc_cfg_if.sink    cfg
);

    localparam int FA_W = $clog2(OUT_PIXELS * MAX_TAPS);
    localparam int QW   = CMD_W + FA_W;

    // configuration registers
    logic [TAPS_W-1:0] taps_reg, taps_next;
    logic [CLIP_W-1:0] clip_min_reg, clip_min_next;
    logic [CLIP_W-1:0] clip_max_reg, clip_max_next;

    // queue between front and back
    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    back_status_t  bk_status;

    // config port never stalls
    assign cfg.ready = 1'b1;

    always_comb
    begin
        taps_next     = taps_reg;
        clip_min_next = clip_min_reg;
        clip_max_next = clip_max_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TAPS:     taps_next     = cfg.data[TAPS_W-1:0];
                CFG_CLIP_MIN: clip_min_next = cfg.data;
                CFG_CLIP_MAX: clip_max_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg     <= TAPS_RST;
            clip_min_reg <= CLIP_MIN_RST;
            clip_max_reg <= CLIP_MAX_RST;
        end
        else
        begin
            taps_reg     <= taps_next;
            clip_min_reg <= clip_min_next;
            clip_max_reg <= clip_max_next;
        end
    end

    // front end: classify and queue each input transfer
    hpsc_front #(.MAX_TAPS(MAX_TAPS)) u_front (
        .src     (src),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    hpsc_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // back end: stores, multiply-accumulate and result register
    hpsc_back #(.MAX_TAPS(MAX_TAPS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .taps_in_use (taps_reg),
        .clip_min    (clip_min_reg),
        .clip_max    (clip_max_reg),
        .dst         (dst),
        .status      (bk_status)
    );

    // the front end never pushes into a full queue
    `HPSC_ASSERT_IMP(a_no_q_overflow, clk, rst_n, q_push, !q_full, "push into full queue")
    // a new result only appears right after the finishing step
    `HPSC_ASSERT_IMP(a_out_from_finish, clk, rst_n, $rose(dst.valid), $past(bk_status.finish), "result without finish")
    // nothing queued and back end idle: no result may appear next
    `HPSC_ASSERT_NXT(a_no_spurious_out, clk, rst_n, q_empty && !bk_status.busy, !$rose(dst.valid), "spurious result")
    // the queue is only popped while the back end is idle
    `HPSC_ASSERT_IMP(a_pop_when_idle, clk, rst_n, q_pop, !bk_status.busy && !q_empty, "pop while busy")

endmodule

// ----- tb/tb_horizontal_polyphase_scaler_1ch_unit.sv -----
// self-checking bench for the single-plane horizontal polyphase scaler: directed and random
// line, factor, start-index and compute transfers, scored against an in-bench pixel predictor
// depends on hpsc_pkg, the channel interfaces and horizontal_polyphase_scaler_1ch_unit
module tb_horizontal_polyphase_scaler_1ch_unit import hpsc_pkg::*; ();

    localparam int FILTER_TAPS   = MAX_TAPS_DEF;
    localparam int FACTOR_WORDS  = OUT_PIXELS * FILTER_TAPS;
    // settle time for a compute in the back end and the items of the two-entry queue behind it
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 215;
    localparam int PHASE_COUNT   = 8;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] out_pos;
    } scaled_pixel_t;

    // mirror of the three stores and the registers; one expected pixel per compute
    class resample_checker;
        logic [PIX_W-1:0]  line_mem [LINE_PIXELS];
        logic [VAL_W-1:0]  factor_mem [FACTOR_WORDS];
        logic [POS_W-1:0]  start_mem [OUT_PIXELS];
        logic [TAPS_W-1:0] taps_reg;
        logic [CLIP_W-1:0] clip_lo_reg;
        logic [CLIP_W-1:0] clip_hi_reg;
        scaled_pixel_t     awaited [$];
        int                error_count;
        int                checked_count;

        function new();
            taps_reg      = TAPS_RST;
            clip_lo_reg   = CLIP_MIN_RST;
            clip_hi_reg   = CLIP_MAX_RST;
            error_count   = 0;
            checked_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TAPS:     taps_reg    = data[TAPS_W-1:0];
                CFG_CLIP_MIN: clip_lo_reg = data[CLIP_W-1:0];
                CFG_CLIP_MAX: clip_hi_reg = data[CLIP_W-1:0];
                default: ;
            endcase
        endfunction

        // filter sum, clamp low bound then high bound, keep bits 21..14
        function logic [PIX_W-1:0] scale_pixel(logic [POS_W-1:0] opix);
            int               n;
            int               t;
            longint           acc;
            longint           lo;
            longint           hi;
            logic [POS_W-1:0] src_idx;
            logic [63:0]      acc_bits;
            n   = (taps_reg > FILTER_TAPS) ? FILTER_TAPS : int'(taps_reg);
            acc = 0;
            for (t = 0; t < n; t++)
            begin
                src_idx = start_mem[opix] + POS_W'(t);
                acc += longint'($signed(factor_mem[opix * FILTER_TAPS + t]))
                       * longint'(line_mem[src_idx]);
            end
            lo = longint'($signed(clip_lo_reg));
            hi = longint'($signed(clip_hi_reg));
            if (acc < lo)
                acc = lo;
            if (acc > hi)
                acc = hi;
            acc_bits = acc;
            return acc_bits[FRAC_BITS +: PIX_W];
        endfunction

        function void note_input(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                 logic [TAP_W-1:0] tap, logic [VAL_W-1:0] value);
            scaled_pixel_t want;
            case (mode)
                MODE_PIXEL:  line_mem[pos] = value[PIX_W-1:0];
                MODE_FACTOR: factor_mem[pos * FILTER_TAPS + tap] = value;
                MODE_START:  start_mem[pos] = value[POS_W-1:0];
                default:
                begin
                    want.pixel   = scale_pixel(pos);
                    want.out_pos = pos;
                    awaited.push_back(want);
                end
            endcase
        endfunction

        function void check_result(logic [PIX_W-1:0] pixel, logic [POS_W-1:0] out_pos);
            scaled_pixel_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing pending: pixel_out %0d out_index %0d",
                         $time, pixel, out_pos);
                error_count++;
                return;
            end
            want = awaited.pop_front();
            checked_count++;
            if (pixel !== want.pixel)
            begin
                $display("%0t: pixel_out of index %0d: expected %0d, actual %0d",
                         $time, want.out_pos, want.pixel, pixel);
                error_count++;
            end
            if (out_pos !== want.out_pos)
            begin
                $display("%0t: out_index: expected %0d, actual %0d",
                         $time, want.out_pos, out_pos);
                error_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hpsc_in_if  src_ch ();
    hpsc_out_if dst_ch ();
    hpsc_cfg_if cfg_ch ();

    horizontal_polyphase_scaler_1ch_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch),
        .dst   (dst_ch),
        .cfg   (cfg_ch)
    );

    resample_checker sb = new();

    // which store entries the stimulus has written so far; a compute is only sent
    // once every entry it reads is known, since unwritten entries are undefined
    bit               line_known   [LINE_PIXELS];
    bit               factor_known [FACTOR_WORDS];
    bit               start_known  [OUT_PIXELS];
    logic [POS_W-1:0] start_copy   [OUT_PIXELS];

    int snd_idle_pct     = 0;
    int rcv_stall_pct    = 0;
    int eff_taps         = TAPS_RST;
    int items_sent       = 0;
    int computes_sent    = 0;
    int settings_applied = 0;
    int quiet_cycles     = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side: random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_ch.ready <= 1'b0;
        else
            dst_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // score each result transfer; watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n && dst_ch.valid && dst_ch.ready)
            sb.check_result(dst_ch.pixel_out, dst_ch.out_index);
        if (!rst_n || (src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one input transfer; valid stays high afterwards so back-to-back items need
    // only one assignment per step, an idle gap in the next call or an idle wait lowers it
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                             input logic [TAP_W-1:0] tap, input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid    <= 1'b1;
        src_ch.mode     <= mode;
        src_ch.position <= pos;
        src_ch.tap      <= tap;
        src_ch.value    <= value;
        @(posedge clk);
        while (!src_ch.ready)
            @(posedge clk);
        sb.note_input(mode, pos, tap, value);
        case (mode)
            MODE_PIXEL:  line_known[pos] = 1'b1;
            MODE_FACTOR: factor_known[pos * FILTER_TAPS + tap] = 1'b1;
            MODE_START:
            begin
                start_known[pos] = 1'b1;
                start_copy[pos]  = value[POS_W-1:0];
            end
            default: computes_sent++;
        endcase
        items_sent++;
    endtask

    // all results in, then let trailing writes drain before touching registers
    task automatic wait_block_idle();
        src_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic load_setting(input int taps, input logic [CLIP_W-1:0] lo,
                                input logic [CLIP_W-1:0] hi);
        wait_block_idle();
        cfg_write(CFG_TAPS, CFG_DATA_W'(taps));
        cfg_write(CFG_CLIP_MIN, lo);
        cfg_write(CFG_CLIP_MAX, hi);
        cfg_ch.valid <= 1'b0;
        eff_taps = (taps > FILTER_TAPS) ? FILTER_TAPS : taps;
        settings_applied++;
    endtask

    // half from a small pool so entries get reused, some at the top end, the rest anywhere
    function automatic logic [POS_W-1:0] pick_out_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return POS_W'($urandom_range(15));
        if (r < 60)
            return POS_W'(OUT_PIXELS - 1 - $urandom_range(7));
        return POS_W'($urandom_range(OUT_PIXELS - 1));
    endfunction

    function automatic logic [VAL_W-1:0] pick_factor();
        logic [VAL_W-1:0] edges [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h4000};
        case ($urandom_range(3))
            0:       return edges[$urandom_range(3)];
            1:       return VAL_W'($urandom_range(18432) - 2048); // kernel-like weights
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic bit pixel_ready(logic [POS_W-1:0] p);
        int               t;
        logic [POS_W-1:0] s;
        if (!start_known[p])
            return 1'b0;
        for (t = 0; t < eff_taps; t++)
        begin
            s = start_copy[p] + POS_W'(t);
            if (!factor_known[p * FILTER_TAPS + t] || !line_known[s])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // well-formed sequence: start index, factors, source pixels, then the compute;
    // missing entries are always filled, known ones rewritten now and then
    task automatic run_pixel_sequence();
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] first_src;
        logic [POS_W-1:0] s;
        int               t;
        p = pick_out_pixel();
        if (!start_known[p] || $urandom_range(3) == 0)
        begin
            // start near the line end a quarter of the time so taps wrap to pixel 0
            if ($urandom_range(3) == 0)
                first_src = POS_W'(LINE_PIXELS - 1 - $urandom_range(7));
            else
                first_src = POS_W'($urandom_range(LINE_PIXELS - 1));
            send_item(MODE_START, p, TAP_W'($urandom), VAL_W'({$urandom, first_src}));
        end
        for (t = 0; t < FILTER_TAPS; t++)
        begin
            if ((t < eff_taps && !factor_known[p * FILTER_TAPS + t]) || $urandom_range(5) == 0)
                send_item(MODE_FACTOR, p, TAP_W'(t), pick_factor());
        end
        for (t = 0; t < eff_taps; t++)
        begin
            s = start_copy[p] + POS_W'(t);
            if (!line_known[s] || $urandom_range(5) == 0)
                send_item(MODE_PIXEL, s, TAP_W'($urandom), VAL_W'($urandom));
        end
        send_item(MODE_COMPUTE, p, TAP_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic random_step();
        int                r;
        logic [MODE_W-1:0] m;
        logic [POS_W-1:0]  p;
        r = $urandom_range(99);
        if (r < 60)
            run_pixel_sequence();
        else if (r < 85)
        begin
            // noise: stray writes anywhere, they may clobber entries of pool pixels
            case ($urandom_range(2))
                0:       m = MODE_PIXEL;
                1:       m = MODE_FACTOR;
                default: m = MODE_START;
            endcase
            send_item(m, POS_W'($urandom), TAP_W'($urandom), VAL_W'($urandom));
        end
        else
        begin
            p = POS_W'($urandom_range(15));
            if (pixel_ready(p))
                send_item(MODE_COMPUTE, p, TAP_W'($urandom), VAL_W'($urandom));
            else
                run_pixel_sequence();
        end
    endtask

    // reset settings: 4 taps, clamp 0 .. 255 << 14
    task automatic run_directed();
        // source pixels around the line end and the start of the line
        send_item(MODE_PIXEL, 11'd2045, 3'd0, 16'h00FF);
        send_item(MODE_PIXEL, 11'd2046, 3'd0, 16'hFF80);
        send_item(MODE_PIXEL, 11'd2047, 3'd0, 16'h7F01);
        send_item(MODE_PIXEL, 11'd0, 3'd0, 16'h80C8);
        send_item(MODE_PIXEL, 11'd1, 3'd0, 16'h0040);
        send_item(MODE_PIXEL, 11'd2, 3'd7, 16'hFFFF);
        // last output pixel: taps run past the line end, extreme factors, sum just in range
        send_item(MODE_START, 11'd2047, 3'd0, 16'h07FD);
        send_item(MODE_FACTOR, 11'd2047, 3'd0, 16'h7FFF);
        send_item(MODE_FACTOR, 11'd2047, 3'd1, 16'h8000);
        send_item(MODE_FACTOR, 11'd2047, 3'd2, 16'h4000);
        send_item(MODE_FACTOR, 11'd2047, 3'd3, 16'h0001);
        send_item(MODE_FACTOR, 11'd2047, 3'd7, 16'h1234);
        send_item(MODE_COMPUTE, 11'd2047, 3'd0, 16'h0000);
        // first output pixel: start index from a value with all bits set
        send_item(MODE_START, 11'd0, 3'd0, 16'hFFFF);
        send_item(MODE_FACTOR, 11'd0, 3'd0, 16'h4000);
        send_item(MODE_FACTOR, 11'd0, 3'd1, 16'h4000);
        send_item(MODE_FACTOR, 11'd0, 3'd2, 16'hC000);
        send_item(MODE_FACTOR, 11'd0, 3'd3, 16'h0000);
        send_item(MODE_COMPUTE, 11'd0, 3'd7, 16'hFFFF);
        // large negative factor on a tap: the sum drops but stays inside the clamp range
        send_item(MODE_FACTOR, 11'd0, 3'd2, 16'h8000);
        send_item(MODE_COMPUTE, 11'd0, 3'd0, 16'h0000);
        // back-to-back computes, with the result side always ready during this directed part
        send_item(MODE_COMPUTE, 11'd2047, 3'd0, 16'h0000);
        send_item(MODE_COMPUTE, 11'd0, 3'd0, 16'h0000);
    endtask

    // per phase: register setting and idling pattern
    task automatic apply_phase(input int ph);
        int          taps;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] swap;
        case (ph)
            0: ; // keep reset settings
            1: load_setting(8, 32'h8000_0000, 32'h7FFF_FFFF);      // widest clamp, full taps
            2: load_setting(0, -32'sd100, CLIP_MAX_RST);            // zero taps
            3: load_setting(15, CLIP_MIN_RST, CLIP_MAX_RST);        // taps saturate to max
            4: load_setting(1, 32'sd1000000, -32'sd3);              // crossed bounds
            5: load_setting(3, -32'sd4194304, 32'sd4194303);        // negative clamped sums
            6:
            begin
                taps = $urandom_range(15);
                lo   = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
                hi   = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
                if ($signed(lo) > $signed(hi) && $urandom_range(3) != 0)
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                load_setting(taps, lo, hi);
            end
            default: load_setting(8, 32'h7FFF_FFFF, 32'h8000_0000); // crossed extremes
        endcase
        case (ph % 4)
            0:
            begin
                snd_idle_pct  = 0;
                rcv_stall_pct = 0;
            end
            1:
            begin
                snd_idle_pct  = 76;
                rcv_stall_pct = 0;
            end
            2:
            begin
                snd_idle_pct  = 0;
                rcv_stall_pct = 76;
            end
            default:
            begin
                snd_idle_pct  = 8;
                rcv_stall_pct = 8;
            end
        endcase
    endtask

    initial
    begin
        int ph;
        int phase_end;
        rst_n           <= 1'b0;
        src_ch.valid    <= 1'b0;
        src_ch.mode     <= MODE_PIXEL;
        src_ch.position <= '0;
        src_ch.tap      <= '0;
        src_ch.value    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_TAPS;
        cfg_ch.data     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            apply_phase(ph);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_step();
        end
        wait_block_idle();

        $display("run: %0d input transfers, %0d computes, %0d results scored",
                 items_sent, computes_sent, sb.checked_count);
        $display("run: %0d register settings across %0d idling phases, %0d mismatches",
                 settings_applied, PHASE_COUNT, sb.error_count);
        if (sb.error_count == 0 && sb.awaited.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hpsc_pkg.sv
rtl/hpsc_if.sv
rtl/hpsc_ram.sv
rtl/hpsc_queue.sv
rtl/hpsc_front.sv
rtl/hpsc_back.sv
rtl/horizontal_polyphase_scaler_1ch_unit.sv
tb/tb_horizontal_polyphase_scaler_1ch_unit.sv
